// File: sv/wfh_pkg.sv
// wfh_pkg: constants, field widths, types and the fold helpers for word_fold_hash64
// shared by wfh_fold and word_fold_hash64; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package wfh_pkg;

  localparam int unsigned HashW      = 64;
  localparam int unsigned LenW       = 40;
  localparam int unsigned WordW      = 64;
  localparam int unsigned BytesW     = 4;
  localparam int unsigned WordBytes  = WordW / 8;
  localparam int unsigned InDataW    = 112;  // len + word + byte count, padded to bytes

  localparam logic [HashW-1:0]  SeedGolden   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [BytesW-1:0] WordBytesMax = 4'd8;

  // one input beat as it sits in the input register
  typedef struct packed {
    logic              start_req;
    logic              last;
    logic [LenW-1:0]   total_length;
    logic [WordW-1:0]  word;
    logic [BytesW-1:0] word_bytes;
  } fold_in_t;

  // keep the low n bytes of a word, n of eight or more keeps all
  function automatic logic [WordW-1:0] keep_low_bytes(input logic [WordW-1:0] w,
                                                      input logic [BytesW-1:0] n);
    logic [WordW-1:0] m;
    m = '0;
    for (int i = 0; i < WordBytes; i++) begin
      if (n > BytesW'(i)) begin
        m[i*8 +: 8] = w[i*8 +: 8];
      end
    end
    return m;
  endfunction

  // multiply by 0x100000001B3 mod 2^64: bits 40, 8, 7, 5, 4, 1, 0
  function automatic logic [HashW-1:0] mul_prime(input logic [HashW-1:0] h);
    return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

endpackage

`default_nettype wire

// File: sv/wfh_fold.sv
// wfh_fold: combinational fold of one beat into the running hash
// depends on wfh_pkg (fold_in_t, keep_low_bytes, mul_prime)
`timescale 1ns / 1ps
`default_nettype none

module wfh_fold
  import wfh_pkg::*;
(
  input  wire fold_in_t           beat_i,
  input  wire logic [HashW-1:0]   hash_i,
  output logic      [HashW-1:0]   hash_o
);

  logic [HashW-1:0] base;
  logic [WordW-1:0] masked;

  // reseed on the first word of a message
  always_comb begin
    if (beat_i.start_req) begin
      base = SeedGolden ^ {{(HashW-LenW){1'b0}}, beat_i.total_length};
    end else begin
      base = hash_i;
    end
  end

  // zero the bytes beyond the valid count
  assign masked = keep_low_bytes(beat_i.word, beat_i.word_bytes);

  // xor and multiply, an empty word leaves the hash alone
  always_comb begin
    if (beat_i.word_bytes == '0) begin
      hash_o = base;
    end else begin
      hash_o = mul_prime(base ^ masked);
    end
  end

endmodule

`default_nettype wire

// File: sv/word_fold_hash64.sv
// word_fold_hash64: 64-bit word-fold hash, input register, fold logic, result register
// depends on wfh_pkg and wfh_fold
//
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tuser=start_req, tlast=last, tdata=total_length, word, word_bytes
//  m_axis  | out | tdata=hash
//
// one word per cycle unless a last word meets a full, stalled result register; each item waits
// in the input register and the hash of a last word goes from there into the result register (m_axis).
// the 64-bit running hash register closes the loop between consecutive words.
// reset clears the running hash to zero and empties both registers.
// a stall on m_axis holds back only a last word; other words keep flowing.
`timescale 1ns / 1ps
`default_nettype none

module word_fold_hash64
  import wfh_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InDataW-1:0]   s_axis_tdata,   // total_length, word, word_bytes, pad
  input  wire logic                 s_axis_tlast,
  input  wire logic                 s_axis_tuser,   // start_req
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [HashW-1:0]     m_axis_tdata    // hash
);

  fold_in_t         in_d, in_q;
  logic             in_vld_q;
  logic             in_fire;
  logic             s1_fire;
  logic [HashW-1:0] hash_d, hash_q;
  logic [HashW-1:0] out_q;
  logic             out_vld_q;

  // unpack the input beat
  always_comb begin
    in_d.start_req    = s_axis_tuser;
    in_d.last         = s_axis_tlast;
    in_d.total_length = s_axis_tdata[LenW-1:0];
    in_d.word         = s_axis_tdata[LenW +: WordW];
    in_d.word_bytes   = s_axis_tdata[LenW+WordW +: BytesW];
  end

  // input stage advances unless a last word meets a full, stalled result register
  assign s1_fire       = in_vld_q && (!in_q.last || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_d;
    end
  end

  // fold logic
  wfh_fold u_fold (
    .beat_i (in_q),
    .hash_i (hash_q),
    .hash_o (hash_d)
  );

  // running hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else if (s1_fire) begin
      hash_q <= hash_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire && in_q.last) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && in_q.last) begin
      out_q <= hash_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // a last word always lands in the result register
  a_last_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && in_q.last) |=> (m_axis_tvalid && m_axis_tdata == hash_q))
    else $error("last word did not reach the result register");

  // an empty word without a start keeps the hash
  a_empty_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !in_q.start_req && in_q.word_bytes == '0) |=> (hash_q == $past(hash_q)))
    else $error("empty word changed the running hash");

  // a held input stage takes no new beat
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !s1_fire) |-> !s_axis_tready)
    else $error("input stage overrun");

  // the hash only moves when a beat leaves the input stage
  a_hash_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(hash_q))
    else $error("running hash changed without a beat");

endmodule

`default_nettype wire
